>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg
// Types and constants of the throttle calibrate and map unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int OUT_BITS      = 8;
    localparam int QUOT_BITS     = 8;
    localparam int PROD_BITS     = SAMPLE_BITS + OUT_BITS;
    localparam int COUNT_BITS    = 16;
    localparam int FAIL_BITS     = 3;
    localparam int FAULT_LIMIT   = 5;
    localparam int MARGIN_DIV    = 20;
    localparam int OP_BITS       = 2;
    localparam int STATUS_BITS   = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_READ  = 2'd0,
        OP_START = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK       = 3'd0,
        STAT_INVALID  = 3'd1,
        STAT_FAULT    = 3'd2,
        STAT_CAL_OK   = 3'd3,
        STAT_SPAN     = 3'd4,
        STAT_NO_VALID = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CAL_SAMPLES = 3'd0,
        CFG_OUT_MIN     = 3'd1,
        CFG_OUT_MAX     = 3'd2,
        CFG_OFFSET      = 3'd3,
        CFG_THRESHOLD   = 3'd4,
        CFG_MIN_RANGE   = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_MARGIN,
        S_POST,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [PROD_BITS-1:0]   numer;
        logic [SAMPLE_BITS-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } div_resp_t;

endpackage

`default_nettype wire

>>> rtl/throttle_calibrate_and_map_unit.sv
// ----------------------------------------------------------------------------
// throttle_calibrate_and_map_unit
// Calibrates raw throttle readings against tracked bounds and maps them to
// an 8-bit throttle value.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command per transaction: a reading, a start of a
//   calibration run or a load of the bounds (operation in s_tuser).
//   m_ channel returns exactly one result per command, status in m_tuser.
//   cfg channel writes the six setup registers; write only while idle.
// Processing:
//   A mapped reading runs a bit-serial 8-step multiply and then an 8-step
//   restoring divide. A new command is accepted only after the previous
//   command's result has been moved to the output register.
//   The reading that closes a successful calibration shares the divider for
//   the span/20 margin.
//   A reading mapped with equal or inverted bounds skips the multiply and
//   the divide; every other command goes straight to its result.
// Reset: bounds go to INIT_LOW/INIT_HIGH, no run open, not calibrated,
//   setup registers to their defaults, m_tvalid low.
// Stall: a finished result waits in the output register; the next command
//   is taken meanwhile and its own result holds until m_tready frees the
//   register.
// ----------------------------------------------------------------------------
`default_nettype none

module throttle_calibrate_and_map_unit
    import tcm_pkg::*;
#(
    parameter int INIT_LOW  = 0,
    parameter int INIT_HIGH = 4095
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // tdata: sample[11:0], sample_valid[12], link_connected[13],
    //        load_low[25:14], load_high[37:26], zero[39:38]
    input  wire logic [39:0]              s_tdata,
    // tuser: operation[1:0]
    input  wire logic [OP_BITS-1:0]       s_tuser,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // tdata: throttle[7:0], activity[8], calibrating[9], calibrated[10],
    //        low_bound[22:11], high_bound[34:23], zero[39:35]
    output logic [39:0]                   m_tdata,
    // tuser: status[2:0]
    output logic [STATUS_BITS-1:0]        m_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready
);

    localparam logic [SAMPLE_BITS-1:0] INIT_LOW_V  = SAMPLE_BITS'(INIT_LOW);
    localparam logic [SAMPLE_BITS-1:0] INIT_HIGH_V = SAMPLE_BITS'(INIT_HIGH);
    localparam int MUL_CNT_BITS = $clog2(OUT_BITS + 1);
    localparam int OUT_USED     = OUT_BITS + 3 + 2 * SAMPLE_BITS;
    localparam int OUT_PAD      = 40 - OUT_USED;

    // setup registers
    logic [COUNT_BITS-1:0]  cal_samples_reg;
    logic [OUT_BITS-1:0]    out_min_reg;
    logic [OUT_BITS-1:0]    out_max_reg;
    logic [OUT_BITS-1:0]    offset_reg;
    logic [OUT_BITS-1:0]    threshold_reg;
    logic [SAMPLE_BITS-1:0] min_range_reg;

    state_t                 state_reg, state_next;

    logic [SAMPLE_BITS-1:0] bound_low_reg,     bound_low_next;
    logic [SAMPLE_BITS-1:0] bound_high_reg,    bound_high_next;
    logic                   cal_active_reg,    cal_active_next;
    logic                   cal_good_reg,      cal_good_next;
    logic [COUNT_BITS-1:0]  cal_count_reg,     cal_count_next;
    logic [SAMPLE_BITS-1:0] run_min_reg,       run_min_next;
    logic [SAMPLE_BITS-1:0] run_max_reg,       run_max_next;
    logic                   seen_valid_reg,    seen_valid_next;
    logic [FAIL_BITS-1:0]   fail_count_reg,    fail_count_next;
    logic [OUT_BITS-1:0]    last_reported_reg, last_reported_next;

    op_t                    op_reg,            op_next;
    logic [SAMPLE_BITS-1:0] sample_reg,        sample_next;
    logic                   valid_reg,         valid_next;
    logic                   link_reg,          link_next;
    logic [SAMPLE_BITS-1:0] load_low_reg,      load_low_next;
    logic [SAMPLE_BITS-1:0] load_high_reg,     load_high_next;

    logic [PROD_BITS-1:0]   acc_reg,           acc_next;
    logic [SAMPLE_BITS-1:0] mcand_reg,         mcand_next;
    logic [OUT_BITS-1:0]    mplier_reg,        mplier_next;
    logic [MUL_CNT_BITS-1:0] mul_cnt_reg,      mul_cnt_next;
    logic [OUT_BITS-1:0]    base_reg,          base_next;

    logic [OUT_BITS-1:0]    res_throttle_reg,  res_throttle_next;
    logic                   res_activity_reg,  res_activity_next;
    status_t                res_status_reg,    res_status_next;

    logic                   m_tvalid_reg,      m_tvalid_next;
    logic [39:0]            m_tdata_reg,       m_tdata_next;
    logic [STATUS_BITS-1:0] m_tuser_reg,       m_tuser_next;

    div_req_t               div_req;
    div_resp_t              div_resp;

    logic                   accept;
    logic                   out_free;
    logic [OUT_BITS:0]      span_sum;
    logic [OUT_BITS-1:0]    span_out;
    logic                   bounds_ok;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] mcand_val;
    logic [SAMPLE_BITS-1:0] new_min;
    logic [SAMPLE_BITS-1:0] new_max;
    logic                   new_seen;
    logic [SAMPLE_BITS-1:0] span_cal;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [COUNT_BITS-1:0]  target;
    logic [FAIL_BITS-1:0]   fail_inc;
    logic                   cal_end;
    logic                   need_margin;
    logic                   need_map;
    logic                   direct_map;
    logic [OUT_BITS-1:0]    thr_val;
    logic [OUT_BITS-1:0]    diff;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign span_sum  = {1'b0, out_min_reg} + {1'b0, offset_reg};
    assign span_out  = ({1'b0, out_max_reg} >= span_sum)
                     ? OUT_BITS'(out_max_reg - out_min_reg - offset_reg) : '0;
    assign bounds_ok = bound_high_reg > bound_low_reg;
    assign clamped   = (sample_reg < bound_low_reg)  ? bound_low_reg
                     : (sample_reg > bound_high_reg) ? bound_high_reg : sample_reg;
    assign mcand_val = clamped - bound_low_reg;

    assign new_min   = (valid_reg && sample_reg < run_min_reg) ? sample_reg : run_min_reg;
    assign new_max   = (valid_reg && sample_reg > run_max_reg) ? sample_reg : run_max_reg;
    assign new_seen  = seen_valid_reg || valid_reg;
    assign span_cal  = new_max - new_min;
    assign cnt_inc   = cal_count_reg + COUNT_BITS'(1);
    assign target    = (cal_samples_reg == '0) ? COUNT_BITS'(1) : cal_samples_reg;
    assign fail_inc  = fail_count_reg + FAIL_BITS'(1);

    assign cal_end     = (op_reg == OP_READ) && cal_active_reg && (cnt_inc >= target);
    assign need_margin = cal_end && new_seen && (span_cal >= min_range_reg);
    assign need_map    = (op_reg == OP_READ) && !cal_active_reg && valid_reg && bounds_ok;
    assign direct_map  = (op_reg == OP_READ) && !cal_active_reg && valid_reg && !bounds_ok;

    assign thr_val = (base_reg != '0) ? OUT_BITS'(base_reg + offset_reg) : '0;
    assign diff    = (thr_val > last_reported_reg) ? OUT_BITS'(thr_val - last_reported_reg)
                                                   : OUT_BITS'(last_reported_reg - thr_val);

    always_comb begin
        div_req.start = ((state_reg == S_MUL) && (mul_cnt_reg == '0))
                     || ((state_reg == S_EVAL) && need_margin);
        if (state_reg == S_MUL) begin
            div_req.numer = acc_reg;
            div_req.denom = bound_high_reg - bound_low_reg;
        end else begin
            div_req.numer = PROD_BITS'(span_cal);
            div_req.denom = SAMPLE_BITS'(MARGIN_DIV);
        end
    end

    tcm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_EVAL;
            end
            S_EVAL: begin
                if (need_map) state_next = S_MUL;
                else if (need_margin) state_next = S_MARGIN;
                else if (direct_map) state_next = S_POST;
                else state_next = S_DONE;
            end
            S_MUL: begin
                if (mul_cnt_reg == '0) state_next = S_DIV;
            end
            S_DIV: begin
                if (div_resp.done) state_next = S_POST;
            end
            S_MARGIN: begin
                if (div_resp.done) state_next = S_DONE;
            end
            S_POST: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        bound_low_next     = bound_low_reg;
        bound_high_next    = bound_high_reg;
        cal_active_next    = cal_active_reg;
        cal_good_next      = cal_good_reg;
        cal_count_next     = cal_count_reg;
        run_min_next       = run_min_reg;
        run_max_next       = run_max_reg;
        seen_valid_next    = seen_valid_reg;
        fail_count_next    = fail_count_reg;
        last_reported_next = last_reported_reg;
        op_next            = op_reg;
        sample_next        = sample_reg;
        valid_next         = valid_reg;
        link_next          = link_reg;
        load_low_next      = load_low_reg;
        load_high_next     = load_high_reg;
        acc_next           = acc_reg;
        mcand_next         = mcand_reg;
        mplier_next        = mplier_reg;
        mul_cnt_next       = mul_cnt_reg;
        base_next          = base_reg;
        res_throttle_next  = res_throttle_reg;
        res_activity_next  = res_activity_reg;
        res_status_next    = res_status_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next        = op_t'(s_tuser);
                    sample_next    = s_tdata[11:0];
                    valid_next     = s_tdata[12];
                    link_next      = s_tdata[13];
                    load_low_next  = s_tdata[25:14];
                    load_high_next = s_tdata[37:26];
                end
            end
            S_EVAL: begin
                res_throttle_next = '0;
                res_activity_next = 1'b0;
                res_status_next   = STAT_OK;
                case (op_reg)
                    OP_START: begin
                        cal_active_next = 1'b1;
                        cal_good_next   = 1'b0;
                        cal_count_next  = '0;
                        run_min_next    = '1;
                        run_max_next    = '0;
                        seen_valid_next = 1'b0;
                    end
                    OP_LOAD: begin
                        cal_active_next = 1'b0;
                        bound_low_next  = load_low_reg;
                        bound_high_next = load_high_reg;
                        cal_good_next   = 1'b1;
                    end
                    OP_READ: begin
                        if (cal_active_reg) begin
                            run_min_next    = new_min;
                            run_max_next    = new_max;
                            seen_valid_next = new_seen;
                            cal_count_next  = cnt_inc;
                            if (!valid_reg) res_status_next = STAT_INVALID;
                            if (cal_end) begin
                                cal_active_next = 1'b0;
                                if (!new_seen) begin
                                    cal_good_next   = 1'b0;
                                    res_status_next = STAT_NO_VALID;
                                end else if (span_cal < min_range_reg) begin
                                    cal_good_next   = 1'b0;
                                    res_status_next = STAT_SPAN;
                                end
                            end
                        end else if (!valid_reg) begin
                            res_status_next = STAT_INVALID;
                            fail_count_next = fail_inc;
                            if (fail_inc >= FAIL_BITS'(FAULT_LIMIT)) begin
                                res_status_next = STAT_FAULT;
                                fail_count_next = '0;
                            end
                        end else begin
                            fail_count_next = '0;
                            acc_next        = '0;
                            mcand_next      = mcand_val;
                            mplier_next     = span_out;
                            mul_cnt_next    = MUL_CNT_BITS'(OUT_BITS);
                            base_next       = out_min_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                if (mul_cnt_reg != '0) begin
                    acc_next     = {acc_reg[PROD_BITS-2:0], 1'b0}
                                 + (mplier_reg[OUT_BITS-1] ? PROD_BITS'(mcand_reg) : '0);
                    mplier_next  = {mplier_reg[OUT_BITS-2:0], 1'b0};
                    mul_cnt_next = mul_cnt_reg - MUL_CNT_BITS'(1);
                end
            end
            S_DIV: begin
                if (div_resp.done) base_next = OUT_BITS'(div_resp.quot + out_min_reg);
            end
            S_MARGIN: begin
                if (div_resp.done) begin
                    bound_low_next  = run_min_reg + SAMPLE_BITS'(div_resp.quot);
                    bound_high_next = run_max_reg - SAMPLE_BITS'(div_resp.quot);
                    cal_good_next   = 1'b1;
                    res_status_next = STAT_CAL_OK;
                end
            end
            S_POST: begin
                res_throttle_next = thr_val;
                if (!link_reg && (diff > threshold_reg)) begin
                    res_activity_next  = 1'b1;
                    last_reported_next = thr_val;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {{OUT_PAD{1'b0}}, bound_high_reg, bound_low_reg,
                                     cal_good_reg, cal_active_reg,
                                     res_activity_reg, res_throttle_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg <= COUNT_BITS'(60);
            out_min_reg     <= '0;
            out_max_reg     <= '1;
            offset_reg      <= '0;
            threshold_reg   <= OUT_BITS'(2);
            min_range_reg   <= SAMPLE_BITS'(150);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CAL_SAMPLES: cal_samples_reg <= cfg_data;
                CFG_OUT_MIN:     out_min_reg     <= cfg_data[OUT_BITS-1:0];
                CFG_OUT_MAX:     out_max_reg     <= cfg_data[OUT_BITS-1:0];
                CFG_OFFSET:      offset_reg      <= cfg_data[OUT_BITS-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[OUT_BITS-1:0];
                CFG_MIN_RANGE:   min_range_reg   <= cfg_data[SAMPLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            bound_low_reg     <= INIT_LOW_V;
            bound_high_reg    <= INIT_HIGH_V;
            cal_active_reg    <= 1'b0;
            cal_good_reg      <= 1'b0;
            cal_count_reg     <= '0;
            run_min_reg       <= '1;
            run_max_reg       <= '0;
            seen_valid_reg    <= 1'b0;
            fail_count_reg    <= '0;
            last_reported_reg <= '0;
            mul_cnt_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            bound_low_reg     <= bound_low_next;
            bound_high_reg    <= bound_high_next;
            cal_active_reg    <= cal_active_next;
            cal_good_reg      <= cal_good_next;
            cal_count_reg     <= cal_count_next;
            run_min_reg       <= run_min_next;
            run_max_reg       <= run_max_next;
            seen_valid_reg    <= seen_valid_next;
            fail_count_reg    <= fail_count_next;
            last_reported_reg <= last_reported_next;
            mul_cnt_reg       <= mul_cnt_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        sample_reg       <= sample_next;
        valid_reg        <= valid_next;
        link_reg         <= link_next;
        load_low_reg     <= load_low_next;
        load_high_reg    <= load_high_next;
        acc_reg          <= acc_next;
        mcand_reg        <= mcand_next;
        mplier_reg       <= mplier_next;
        base_reg         <= base_next;
        res_throttle_reg <= res_throttle_next;
        res_activity_reg <= res_activity_next;
        res_status_reg   <= res_status_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> rtl/tcm_divider.sv
// ----------------------------------------------------------------------------
// tcm_divider
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUOT_BITS, i.e. the upper part of the numerator is below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_divider
    import tcm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire div_req_t  req,
    output div_resp_t      resp
);

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

    logic [SAMPLE_BITS-1:0] rem_reg,   rem_next;
    logic [QUOT_BITS-1:0]   shift_reg, shift_next;
    logic [SAMPLE_BITS-1:0] denom_reg, denom_next;
    logic [CNT_BITS-1:0]    cnt_reg,   cnt_next;
    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;

    logic [SAMPLE_BITS:0]   trial;
    logic                   fits;

    assign trial = {rem_reg, shift_reg[QUOT_BITS-1]};
    assign fits  = trial >= {1'b0, denom_reg};

    always_comb begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        denom_next = denom_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            rem_next   = req.numer[PROD_BITS-1:QUOT_BITS];
            shift_next = req.numer[QUOT_BITS-1:0];
            denom_next = req.denom;
            cnt_next   = CNT_BITS'(QUOT_BITS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = fits ? SAMPLE_BITS'(trial - {1'b0, denom_reg})
                              : trial[SAMPLE_BITS-1:0];
            shift_next = {shift_reg[QUOT_BITS-2:0], fits};
            cnt_next   = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        denom_reg <= denom_next;
    end

    assign resp.done = done_reg;
    assign resp.quot = shift_reg;

endmodule

`default_nettype wire

>>> rtl/tcm_checker.sv
// ----------------------------------------------------------------------------
// tcm_checker
// Port-level checks of the throttle calibrate and map unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcm_checker
    import tcm_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic [39:0]              m_tdata,
    input wire logic [STATUS_BITS-1:0]   m_tuser,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready
);

    logic in_xfer;
    logic cal_done;
    logic cal_fail;

    assign in_xfer  = s_tvalid && s_tready;
    assign cal_done = m_tvalid && (m_tuser == STAT_CAL_OK);
    assign cal_fail = m_tvalid && ((m_tuser == STAT_SPAN) || (m_tuser == STAT_NO_VALID));

    `ASSERT_NEXT_CYCLE(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `ASSERT_NEXT_CYCLE(a_one_at_a_time, aclk, aresetn, in_xfer, !s_tready,
        "command taken while previous one in flight")

    `ASSERT_SAME_CYCLE(a_cal_quiet, aclk, aresetn, m_tvalid && m_tdata[9],
        (m_tdata[7:0] == 8'd0) && !m_tdata[8], "output driven during calibration")

    `ASSERT_SAME_CYCLE(a_cal_ok, aclk, aresetn, cal_done,
        m_tdata[10] && !m_tdata[9] && (m_tdata[34:23] >= m_tdata[22:11]),
        "calibration success with bad flags or bounds")

    `ASSERT_SAME_CYCLE(a_cal_fail, aclk, aresetn, cal_fail,
        !m_tdata[10] && !m_tdata[9], "calibration failure left flags set")

endmodule

bind throttle_calibrate_and_map_unit tcm_checker u_checker (.*);

`default_nettype wire

>>> verif/throttle_calibrate_and_map_unit_test.sv
// ----------------------------------------------------------------------------
// throttle_calibrate_and_map_unit_test
// Self-checking bench for the throttle calibrate and map unit. Commands go in
// on the s_ stream in random bursts while the m_ side stalls on its own
// pattern. An in-bench model of bounds, calibration runs, mapping, activity
// and fault counting predicts each result; results are compared field by
// field in order. Directed cases cover the field extremes, every command and
// the corner cases of calibration and mapping. Random traffic then runs
// under eight register settings that include the extremes.
// ----------------------------------------------------------------------------
module throttle_calibrate_and_map_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tcm_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNKNOWN    = 2'd3;
    localparam logic [11:0]        SAMPLE_MAX    = 12'hFFF;
    localparam int                 SETTLE_CYCLES = 32;
    localparam int                 LIMIT_CYCLES  = 600000;
    localparam int                 RANDOM_ITEMS  = 480;

    typedef struct packed {
        logic [7:0]  throttle;
        logic        activity;
        logic        calibrating;
        logic        calibrated;
        status_t     status;
        logic [11:0] low_bound;
        logic [11:0] high_bound;
    } tcm_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic [39:0]              s_tdata;
    logic [OP_BITS-1:0]       s_tuser;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [39:0]              m_tdata;
    logic [STATUS_BITS-1:0]   m_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     cfg_valid;
    logic                     cfg_ready;

    // register shadow
    logic [15:0] cfg_cal_samples = 16'd60;
    logic [7:0]  cfg_out_min     = 8'd0;
    logic [7:0]  cfg_out_max     = 8'd255;
    logic [7:0]  cfg_offset      = 8'd0;
    logic [7:0]  cfg_threshold   = 8'd2;
    logic [11:0] cfg_min_range   = 12'd150;

    // predicted block state
    logic [11:0] bnd_lo        = 12'd0;
    logic [11:0] bnd_hi        = SAMPLE_MAX;
    logic        run_open      = 1'b0;
    logic        cal_ok        = 1'b0;
    logic [15:0] run_count     = 16'd0;
    logic [11:0] run_lo        = SAMPLE_MAX;
    logic [11:0] run_hi        = 12'd0;
    logic        run_any_valid = 1'b0;
    int          fault_run     = 0;
    logic [7:0]  last_throttle = 8'd0;

    tcm_result_t expected_results[$];
    tcm_result_t expected_head;

    int cycle_count      = 0;
    int mismatch_total   = 0;
    int checked_count    = 0;
    int command_count    = 0;
    int cal_pass_count   = 0;
    int cal_narrow_count = 0;
    int cal_none_count   = 0;
    int fault_count      = 0;
    int activity_count   = 0;
    int burst_left       = 1;
    bit gaps_on          = 1'b1;

    throttle_calibrate_and_map_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [7:0] map_reading(input logic [11:0] smp);
        int omin, omax, off, lo_i, hi_i, span, v, base;
        omin = cfg_out_min;
        omax = cfg_out_max;
        off  = cfg_offset;
        lo_i = bnd_lo;
        hi_i = bnd_hi;
        span = (omax >= omin + off) ? omax - omin - off : 0;
        if (hi_i <= lo_i) begin
            base = omin;
        end else begin
            v = smp;
            if (v < lo_i) v = lo_i;
            if (v > hi_i) v = hi_i;
            base = (v - lo_i) * span / (hi_i - lo_i) + omin;
        end
        base = base & 255;
        if (base != 0) base = (base + off) & 255;
        return base[7:0];
    endfunction

    function automatic tcm_result_t predict_result(
        input logic [OP_BITS-1:0] op,
        input logic [11:0]        smp,
        input logic               ok,
        input logic               lnk,
        input logic [11:0]        lo,
        input logic [11:0]        hi
    );
        tcm_result_t r;
        int target, span, margin, diff, thr, prev;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_START: begin
                run_open      = 1'b1;
                cal_ok        = 1'b0;
                run_count     = '0;
                run_lo        = SAMPLE_MAX;
                run_hi        = '0;
                run_any_valid = 1'b0;
            end
            OP_LOAD: begin
                run_open = 1'b0;
                bnd_lo   = lo;
                bnd_hi   = hi;
                cal_ok   = 1'b1;
            end
            OP_READ: begin
                if (run_open) begin
                    target = (cfg_cal_samples == 0) ? 1 : cfg_cal_samples;
                    if (ok) begin
                        if (smp < run_lo) run_lo = smp;
                        if (smp > run_hi) run_hi = smp;
                        run_any_valid = 1'b1;
                    end else begin
                        r.status = STAT_INVALID;
                    end
                    run_count = run_count + 16'd1;
                    if (run_count >= target) begin
                        run_open = 1'b0;
                        span = run_hi;
                        span = span - run_lo;
                        if (!run_any_valid) begin
                            cal_ok   = 1'b0;
                            r.status = STAT_NO_VALID;
                            cal_none_count++;
                        end else if (span < cfg_min_range) begin
                            cal_ok   = 1'b0;
                            r.status = STAT_SPAN;
                            cal_narrow_count++;
                        end else begin
                            margin   = span / MARGIN_DIV;
                            bnd_lo   = 12'(run_lo + margin);
                            bnd_hi   = 12'(run_hi - margin);
                            cal_ok   = 1'b1;
                            r.status = STAT_CAL_OK;
                            cal_pass_count++;
                        end
                    end
                end else if (!ok) begin
                    fault_run++;
                    r.status = STAT_INVALID;
                    if (fault_run >= FAULT_LIMIT) begin
                        r.status  = STAT_FAULT;
                        fault_run = 0;
                        fault_count++;
                    end
                end else begin
                    fault_run  = 0;
                    r.throttle = map_reading(smp);
                    if (!lnk) begin
                        thr  = r.throttle;
                        prev = last_throttle;
                        diff = (thr > prev) ? thr - prev : prev - thr;
                        if (diff > cfg_threshold) begin
                            r.activity    = 1'b1;
                            last_throttle = r.throttle;
                            activity_count++;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.calibrating = run_open;
        r.calibrated  = cal_ok;
        r.low_bound   = bnd_lo;
        r.high_bound  = bnd_hi;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s is %0h, expected %0h",
                 checked_count, what, got, want);
        mismatch_total++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                expected_head = expected_results.pop_front();
                checked_count++;
                if (m_tdata[7:0] != expected_head.throttle)
                    report_mismatch("throttle", m_tdata[7:0], expected_head.throttle);
                if (m_tdata[8] != expected_head.activity)
                    report_mismatch("activity", m_tdata[8], expected_head.activity);
                if (m_tdata[9] != expected_head.calibrating)
                    report_mismatch("calibrating", m_tdata[9], expected_head.calibrating);
                if (m_tdata[10] != expected_head.calibrated)
                    report_mismatch("calibrated", m_tdata[10], expected_head.calibrated);
                if (m_tuser != expected_head.status)
                    report_mismatch("status", m_tuser, expected_head.status);
                if (m_tdata[22:11] != expected_head.low_bound)
                    report_mismatch("low_bound", m_tdata[22:11], expected_head.low_bound);
                if (m_tdata[34:23] != expected_head.high_bound)
                    report_mismatch("high_bound", m_tdata[34:23], expected_head.high_bound);
            end
        end
    end

    initial begin : ready_pattern
        int mode, hold;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(16, 64);
            repeat (hold) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = $urandom_range(0, 1);
                    2:       m_tready = ($urandom_range(0, 5) == 0);
                    default: m_tready = ~m_tready;
                endcase
            end
        end
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_results.size());
        $display("Verification failed");
        $finish;
    end

    task automatic issue(
        input logic [OP_BITS-1:0] op,
        input logic [11:0]        smp,
        input logic               ok,
        input logic               lnk,
        input logic [11:0]        lo,
        input logic [11:0]        hi
    );
        int gap;
        @(negedge aclk);
        s_tdata  = {2'b00, hi, lo, lnk, ok, smp};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_result(op, smp, ok, lnk, lo, hi));
        if (op != OP_UNKNOWN) command_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic issue_reading(input logic [11:0] smp, input logic ok, input logic lnk);
        issue(OP_READ, smp, ok, lnk, 12'($urandom), 12'($urandom));
    endtask

    task automatic issue_start();
        issue(OP_START, 12'($urandom), 1'($urandom), 1'($urandom), 12'($urandom),
              12'($urandom));
    endtask

    task automatic issue_load(input logic [11:0] lo, input logic [11:0] hi);
        issue(OP_LOAD, 12'($urandom), 1'($urandom), 1'($urandom), lo, hi);
    endtask

    // hold off new commands and let every pending result drain
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CAL_SAMPLES: cfg_cal_samples = value;
            CFG_OUT_MIN:     cfg_out_min     = value[7:0];
            CFG_OUT_MAX:     cfg_out_max     = value[7:0];
            CFG_OFFSET:      cfg_offset      = value[7:0];
            CFG_THRESHOLD:   cfg_threshold   = value[7:0];
            CFG_MIN_RANGE:   cfg_min_range   = value[11:0];
            default: ;
        endcase
    endtask

    task automatic configure(
        input logic [15:0] samples,
        input logic [7:0]  omin,
        input logic [7:0]  omax,
        input logic [7:0]  offset,
        input logic [7:0]  threshold,
        input logic [11:0] mrange
    );
        quiesce();
        write_reg(CFG_CAL_SAMPLES, samples);
        write_reg(CFG_OUT_MIN, {8'd0, omin});
        write_reg(CFG_OUT_MAX, {8'd0, omax});
        write_reg(CFG_OFFSET, {8'd0, offset});
        write_reg(CFG_THRESHOLD, {8'd0, threshold});
        write_reg(CFG_MIN_RANGE, {4'd0, mrange});
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return SAMPLE_MAX;
            2:       return 12'(bnd_lo + $urandom_range(0, 2) - 1);
            3:       return 12'(bnd_hi + $urandom_range(0, 2) - 1);
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic test_reset_mapping();
        issue_reading(12'd0, 1'b1, 1'b0);
        issue_reading(SAMPLE_MAX, 1'b1, 1'b0);
        issue_reading(12'd2048, 1'b1, 1'b1);
        issue_reading(12'd2048, 1'b1, 1'b0);
        issue(OP_UNKNOWN, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MAX);
        repeat (FAULT_LIMIT + 1) issue_reading(SAMPLE_MAX, 1'b0, 1'b0);
        issue_reading(12'd1, 1'b1, 1'b0);
    endtask

    task automatic test_calibration();
        configure(16'd3, 8'd0, 8'd255, 8'd0, 8'd2, 12'd150);
        issue_start();
        issue_reading(12'd500, 1'b1, 1'b0);
        issue_reading(12'd4000, 1'b0, 1'b0);
        issue_reading(12'd3000, 1'b1, 1'b0);
        issue_reading(12'd625, 1'b1, 1'b0);
        issue_start();
        issue_reading(12'd1000, 1'b1, 1'b0);
        issue_reading(12'd1100, 1'b1, 1'b0);
        issue_reading(12'd1050, 1'b1, 1'b0);
        issue_start();
        repeat (3) issue_reading(SAMPLE_MAX, 1'b0, 1'b0);
        issue_start();
        issue_reading(12'd7, 1'b1, 1'b0);
        issue_start();
        issue_reading(12'd0, 1'b1, 1'b0);
        issue_reading(SAMPLE_MAX, 1'b1, 1'b0);
        issue_reading(12'd2000, 1'b1, 1'b0);
        issue_load(12'd3000, 12'd1000);
        issue_reading(12'd2000, 1'b1, 1'b0);
        configure(16'd0, 8'd0, 8'd255, 8'd0, 8'd2, 12'd0);
        issue_start();
        issue_reading(12'd1234, 1'b1, 1'b0);
        issue_reading(12'd1234, 1'b1, 1'b0);
        configure(16'hFFFF, 8'd0, 8'd255, 8'd0, 8'd2, 12'd150);
        issue_start();
        repeat (4) issue_reading(12'($urandom), 1'b1, 1'b0);
        issue_load(12'd0, SAMPLE_MAX);
    endtask

    task automatic test_random_traffic();
        int phase, quota, pick, n, width, lo_s, hi_s;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(16'd60, 8'd0, 8'd255, 8'd0, 8'd2, 12'd150);
                1: configure(16'd4, 8'd0, 8'd255, 8'd0, 8'd0, 12'd0);
                2: configure(16'd1, 8'd255, 8'd0, 8'd255, 8'd255, SAMPLE_MAX);
                3: configure(16'd7, 8'd10, 8'd200, 8'd30, 8'd5, 12'd300);
                4: configure(16'd3, 8'd128, 8'd128, 8'd0, 8'd1, 12'd100);
                5: configure(16'd2, 8'd0, 8'd255, 8'd255, 8'd3, 12'd0);
                6: configure(16'd5, 8'd1, 8'd254, 8'd1, 8'd254, 12'd4094);
                default: configure(16'($urandom_range(1, 12)), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom),
                                   12'($urandom_range(0, 1000)));
            endcase
            gaps_on = (phase % 3 != 1);
            quota = command_count + RANDOM_ITEMS / 8;
            while (command_count < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    repeat ($urandom_range(1, 8))
                        issue_reading(pick_sample(), $urandom_range(0, 9) != 0,
                                      1'($urandom));
                end else if (pick < 72) begin
                    issue_start();
                    n = (cfg_cal_samples == 0) ? 1 : cfg_cal_samples;
                    // cut some runs short so a later command interrupts them
                    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
                    width = $urandom_range(0, 1) ? $urandom_range(0, 400) : 4095;
                    lo_s  = (width == 4095) ? 0 : $urandom_range(0, 4095);
                    hi_s  = (lo_s + width > 4095) ? 4095 : lo_s + width;
                    repeat (n)
                        issue_reading(12'($urandom_range(lo_s, hi_s)),
                                      $urandom_range(0, 19) != 0, 1'($urandom));
                end else if (pick < 82) begin
                    lo_s = $urandom_range(0, 4095);
                    hi_s = $urandom_range(0, 4095);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: hi_s = lo_s;
                        default: if (hi_s < lo_s) {lo_s, hi_s} = {hi_s, lo_s};
                    endcase
                    issue_load(12'(lo_s), 12'(hi_s));
                end else if (pick < 92) begin
                    repeat ($urandom_range(4, 7))
                        issue_reading(12'($urandom), 1'b0, 1'($urandom));
                end else begin
                    issue(OP_UNKNOWN, 12'($urandom), 1'($urandom), 1'($urandom),
                          12'($urandom), 12'($urandom));
                end
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_READ;
        s_tvalid  = 1'b0;
        cfg_index = CFG_CAL_SAMPLES;
        cfg_data  = '0;
        cfg_valid = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_mapping();
        test_calibration();
        test_random_traffic();
        quiesce();

        $display("%0d commands sent, %0d results checked across eight register settings",
                 command_count, checked_count);
        $display("calibrations passed/narrow/without readings %0d/%0d/%0d, faults %0d, activity %0d",
                 cal_pass_count, cal_narrow_count, cal_none_count, fault_count, activity_count);
        if (mismatch_total == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> throttle_calibrate_and_map_unit.f
+incdir+rtl
rtl/tcm_pkg.sv
rtl/tcm_divider.sv
rtl/throttle_calibrate_and_map_unit.sv
rtl/tcm_checker.sv
verif/throttle_calibrate_and_map_unit_test.sv
